FILE: hw/rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

  localparam int IDX_W  = 2;   // row and column fields on the stream
  localparam int DATA_W = 16;  // element width, Q16.0
  localparam int PROD_W = 32;  // full product of two elements
  localparam int ACC_W  = 40;  // dot-product accumulator

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT
  } state_t;

  // Control that travels beside one multiply-accumulate operand pair.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: hw/rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mme_mac.sv
// Shared multiply-accumulate unit: registered product, then 40-bit accumulate.
module mme_mac
  import mme_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  mac_ctl_t                 ctl,
  output logic        [ACC_W-1:0]  acc,
  output logic                     done
);

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_q;
  logic        [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      ctl_q <= '0;
      done  <= 1'b0;
    end else begin
      ctl_q <= ctl;
      done  <= ctl_q.valid & ctl_q.last;
    end
    if (ctl_q.valid) begin
      // first term loads, the rest add; wraps modulo 2^40
      acc <= ctl_q.first ? prod_ext : acc + prod_ext;
    end
  end

endmodule

FILE: hw/rtl/matrix_multiply_engine.sv
// Matrix multiply engine: C = A x B over one shared multiply-accumulate unit.
// Operation: a write beat stores one element; a compute beat emits ROWS*COLS results,
//   each made by INNER operand reads, a wait for the MAC pipeline to drain and
//   an emit that waits until the output register is free.
// Throughput is set by the single MAC: one product term per cycle in ISSUE; s_tready
//   is low while a product is being computed. rst (synchronous) clears control
//   state only; A and B contents are undefined until written.
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int ROWS  = 4,
  parameter int INNER = 4,
  parameter int COLS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [1:0] row_index, [3:2] col_index,
                                 // [19:4] element_value, [23:20] zero
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [1:0] out_row, [3:2] out_col,
                                 // [43:4] product_value, [47:44] zero
  output logic        m_tlast    // last_flag
);

  // Counter and address widths follow the matrix shape.
  localparam int RW    = (ROWS  > 1) ? $clog2(ROWS)  : 1;
  localparam int KW    = (INNER > 1) ? $clog2(INNER) : 1;
  localparam int CW    = (COLS  > 1) ? $clog2(COLS)  : 1;
  localparam int A_DEP = ROWS * INNER;
  localparam int B_DEP = INNER * COLS;
  localparam int AAW   = (A_DEP > 1) ? $clog2(A_DEP) : 1;
  localparam int BAW   = (B_DEP > 1) ? $clog2(B_DEP) : 1;

  // Input beat fields
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [DATA_W-1:0] in_val;
  op_t               in_op;
  logic              s_acc;

  assign in_row = s_tdata[1:0];
  assign in_col = s_tdata[3:2];
  assign in_val = s_tdata[19:4];
  assign in_op  = op_t'(s_tuser);
  assign s_acc  = s_tvalid & s_tready;

  // Sequencer state and loop counters (i row, j column, k inner term)
  state_t        state, state_next;
  logic [RW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [KW-1:0] k, k_next;

  logic i_end, j_end, k_end;
  assign i_end = (i == RW'(ROWS - 1));
  assign j_end = (j == CW'(COLS - 1));
  assign k_end = (k == KW'(INNER - 1));

  // Memory ports
  logic              a_we, b_we;
  logic [AAW-1:0]    a_waddr, a_raddr;
  logic [BAW-1:0]    b_waddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  // MAC control: issued with the read, registered once to line up with the read data
  mac_ctl_t         issue_ctl, rd_ctl;
  logic [ACC_W-1:0] acc;
  logic             done;

  // Output register
  logic              out_free;
  logic              load_out;
  logic [IDX_W-1:0]  out_row, out_col;
  logic [ACC_W-1:0]  out_val;
  logic              out_last;

  assign out_free = ~m_tvalid | m_tready;

  // Writes land only while idle, so the read ports never collide with them.
  assign a_waddr = AAW'(32'(in_row) * INNER + 32'(in_col));
  assign b_waddr = BAW'(32'(in_row) * COLS + 32'(in_col));
  assign a_raddr = AAW'(32'(i) * INNER + 32'(k));
  assign b_raddr = BAW'(32'(k) * COLS + 32'(j));

  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    if (s_acc) begin
      unique case (in_op)
        OP_WR_A: a_we = (32'(in_row) < ROWS)  && (32'(in_col) < INNER);
        OP_WR_B: b_we = (32'(in_row) < INNER) && (32'(in_col) < COLS);
        default: ;
      endcase
    end
  end

  mme_ram #(.WIDTH(DATA_W), .DEPTH(A_DEP)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_val),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(.WIDTH(DATA_W), .DEPTH(B_DEP)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_val),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mme_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .a    ($signed(a_rdata)),
    .b    ($signed(b_rdata)),
    .ctl  (rd_ctl),
    .acc  (acc),
    .done (done)
  );

  // Sequencer: ISSUE walks k for one (i, j), WAIT drains the MAC pipe,
  // EMIT hands the sum to the output register and steps to the next element.
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    issue_ctl  = '0;
    load_out   = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc && in_op == OP_COMPUTE) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue_ctl.valid = 1'b1;
        issue_ctl.first = (k == '0);
        issue_ctl.last  = k_end;
        if (k_end) begin
          k_next     = '0;
          state_next = ST_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_WAIT: begin
        if (done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (j_end) begin
            j_next = '0;
            if (i_end) begin
              i_next     = '0;
              state_next = ST_IDLE;
            end else begin
              i_next     = i + 1'b1;
              state_next = ST_ISSUE;
            end
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      rd_ctl <= '0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      j      <= j_next;
      k      <= k_next;
      rd_ctl <= issue_ctl;
    end
  end

  // Result register: holds a finished element until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      out_row  <= IDX_W'(i);
      out_col  <= IDX_W'(j);
      out_val  <= acc;
      out_last <= i_end & j_end;
    end
  end

  assign m_tdata = {4'b0, out_val, out_col, out_row};
  assign m_tlast = out_last;

endmodule

FILE: dv/mme_checker.sv
`timescale 1ns / 100ps
// Checker for the matrix multiply engine: predicts product beats and compares them.
module mme_checker
  import mme_pkg::*;
#(
  parameter int ROWS  = 4,
  parameter int INNER = 4,
  parameter int COLS  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending_results
);

  localparam int A_AW = (ROWS * INNER > 1) ? $clog2(ROWS * INNER) : 1;
  localparam int B_AW = (INNER * COLS > 1) ? $clog2(INNER * COLS) : 1;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] sum;
    logic             last;
  } c_elem_t;

  logic signed [DATA_W-1:0] mat_a [ROWS*INNER];
  logic signed [DATA_W-1:0] mat_b [INNER*COLS];
  c_elem_t                  product_q [$];
  int                       mismatches = 0;

  // 40-bit dot product of A row i and B column j, wrapping like the accumulator
  function automatic logic [ACC_W-1:0] dot_product(int i, int j);
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] term;
    acc = '0;
    for (int k = 0; k < INNER; k++) begin
      term = mat_a[A_AW'(i*INNER + k)] * mat_b[B_AW'(k*COLS + j)];
      acc  = acc + term;
    end
    return acc;
  endfunction

  always @(posedge clk) begin : watch
    logic [IDX_W-1:0]         wr_row;
    logic [IDX_W-1:0]         wr_col;
    logic signed [DATA_W-1:0] wr_val;
    c_elem_t                  want;
    c_elem_t                  got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        wr_row = s_tdata[1:0];
        wr_col = s_tdata[3:2];
        wr_val = s_tdata[19:4];
        case (s_tuser)
          OP_WR_A: begin
            if (wr_row < ROWS && wr_col < INNER)
              mat_a[A_AW'(wr_row*INNER + wr_col)] = wr_val;
          end
          OP_WR_B: begin
            if (wr_row < INNER && wr_col < COLS)
              mat_b[B_AW'(wr_row*COLS + wr_col)] = wr_val;
          end
          OP_COMPUTE: begin
            for (int i = 0; i < ROWS; i++) begin
              for (int j = 0; j < COLS; j++) begin
                want.row  = IDX_W'(i);
                want.col  = IDX_W'(j);
                want.sum  = dot_product(i, j);
                want.last = (i == ROWS - 1 && j == COLS - 1);
                product_q.push_back(want);
              end
            end
          end
          default: ;  // unused opcode, dropped
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.row  = m_tdata[1:0];
        got.col  = m_tdata[3:2];
        got.sum  = m_tdata[43:4];
        got.last = m_tlast;
        if (product_q.size() == 0) begin
          $error("result beat with no product element pending");
          mismatches++;
        end else begin
          want = product_q.pop_front();
          if (got.row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, got.row);
            mismatches++;
          end
          if (got.col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, got.col);
            mismatches++;
          end
          if (got.sum !== want.sum) begin
            $error("product_value: expected %0d, actual %0d",
                   $signed(want.sum), $signed(got.sum));
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last_flag: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending_results <= product_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives matrix loads and compute beats and gives the verdict.
module tb
  import mme_pkg::*;
();

  localparam int ROWS         = 4;
  localparam int INNER        = 4;
  localparam int COLS         = 4;
  localparam int RANDOM_ITEMS = 400;
  // the random run's worst case stays far below this limit
  localparam int CYCLE_LIMIT  = 200000;
  // extra wait after the last expected result, so stray result beats are still seen
  localparam int DRAIN_CYCLES = 300;
  // opcode with no meaning; the engine drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;  // [1:0] row_index, [3:2] col_index,
                               // [19:4] element_value, [23:20] zero
  logic [1:0]  s_tuser  = '0;  // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [1:0] out_row, [3:2] out_col,
                               // [43:4] product_value, [47:44] zero
  logic        m_tlast;        // last_flag

  int          fail_count;
  int          pending_results;
  int          cycle_cnt   = 0;
  int          sent_beats  = 0;  // source beats issued, sets calm stretches
  int          taken_beats = 0;  // result beats taken, same for the sink
  int unsigned sink_stall  = 0;

  always #5 clk = ~clk;

  matrix_multiply_engine #(
    .ROWS (ROWS),
    .INNER(INNER),
    .COLS (COLS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  mme_checker #(
    .ROWS (ROWS),
    .INNER(INNER),
    .COLS (COLS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // Idle cycles before a beat; calm stretches run with no gaps at all.
  function automatic int unsigned pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 7);
  endfunction

  // Source side. Entered at a rising edge; returns at the edge that took the beat.
  // tvalid stays high across back-to-back beats, so it is never dropped and
  // raised in one step.
  task automatic send_beat(input logic [1:0] op, input logic [1:0] row,
                           input logic [1:0] col, input logic [15:0] val);
    int unsigned gap;
    gap = pick_wait((sent_beats / 40) % 3 == 2);
    sent_beats++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, val, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Sink side: after each taken result beat, hold tready low for a stall from pick_wait.
  always @(posedge clk) begin : sink
    int unsigned n;
    if (rst) begin
      m_tready   <= 1'b0;
      sink_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      n = pick_wait((taken_beats / 48) % 3 == 1);
      taken_beats++;
      sink_stall <= n;
      m_tready   <= (n == 0);
    end else if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      m_tready   <= (sink_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          done;
    int unsigned pick;
    logic [1:0]  op;
    logic [15:0] val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: every entry is written before the first compute, since the
    // stores hold nothing defined after reset. All-minimum operands give the
    // largest positive sum, 4 * 2^30.
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < INNER; c++) send_beat(OP_WR_A, 2'(r), 2'(c), 16'h8000);
    for (int r = 0; r < INNER; r++)
      for (int c = 0; c < COLS; c++) send_beat(OP_WR_B, 2'(r), 2'(c), 16'h8000);
    send_beat(OP_COMPUTE, 2'd0, 2'd0, 16'h0000);
    // unused opcode with all-ones fields: must yield nothing
    send_beat(OP_UNUSED, 2'd3, 2'd3, 16'hffff);
    // row 0 at the maximum: most negative sums in row 0
    for (int c = 0; c < INNER; c++) send_beat(OP_WR_A, 2'd0, 2'(c), 16'h7fff);
    // row 3 of B to -1 and zero mixed in
    send_beat(OP_WR_B, 2'd3, 2'd0, 16'hffff);
    send_beat(OP_WR_B, 2'd3, 2'd1, 16'h0000);
    send_beat(OP_COMPUTE, 2'd3, 2'd3, 16'hffff);

    // Random: mostly loads with random content, a compute now and then,
    // and some unused-opcode noise that does not count toward the total.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       val = 16'h8000;
        1:       val = 16'h7fff;
        2:       val = 16'hffff;
        3:       val = 16'h0000;
        default: val = 16'($urandom());
      endcase
      if (pick < 8)       op = OP_COMPUTE;
      else if (pick < 12) op = OP_UNUSED;
      else if (pick < 56) op = OP_WR_A;
      else                op = OP_WR_B;
      send_beat(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), val);
      if (op != OP_UNUSED) done++;
    end
    s_tvalid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
